@@ sv/ds_twr_pkg.sv @@
// Shared constants and types for the double-sided two-way ranging distance unit.
`default_nettype none

package ds_twr_pkg;

    localparam int STAMP_IN_W = 32;
    localparam int ANCHOR_W   = 8;
    localparam int SCALE_W    = 24;
    localparam int DIST_W     = 31;
    localparam int MUL_SPLIT  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307387;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic                pos;
        logic [ANCHOR_W-1:0] anchor;
    } ctrl_t;

    typedef struct packed {
        logic [ANCHOR_W-1:0] anchor_out;
        logic [DIST_W-1:0]   distance_mm;
        logic                zero_divisor;
    } res_t;

endpackage

`default_nettype wire

@@ sv/ds_twr_channels.sv @@
// Handshake channel interfaces for timestamp sets, results and the scale register.
`default_nettype none

interface ds_twr_set_if;
    logic        valid;
    logic        ready;
    logic        set_valid;
    logic [ds_twr_pkg::ANCHOR_W-1:0]   anchor_number;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] poll_sent_time;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] reply_received_time;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] final_sent_time;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] poll_received_time;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] reply_sent_time;
    logic [ds_twr_pkg::STAMP_IN_W-1:0] final_received_time;

    modport source (
        output valid, set_valid, anchor_number, poll_sent_time, reply_received_time,
               final_sent_time, poll_received_time, reply_sent_time, final_received_time,
        input  ready
    );
    modport sink (
        input  valid, set_valid, anchor_number, poll_sent_time, reply_received_time,
               final_sent_time, poll_received_time, reply_sent_time, final_received_time,
        output ready
    );
endinterface

interface ds_twr_result_if;
    logic valid;
    logic ready;
    logic [ds_twr_pkg::ANCHOR_W-1:0] anchor_out;
    logic [ds_twr_pkg::DIST_W-1:0]   distance_mm;
    logic                            zero_divisor;

    modport source (output valid, anchor_out, distance_mm, zero_divisor, input ready);
    modport sink (input valid, anchor_out, distance_mm, zero_divisor, output ready);
endinterface

interface ds_twr_cfg_if;
    logic valid;
    logic ready;
    logic [ds_twr_pkg::SCALE_W-1:0] mm_per_unit_q16;

    modport source (output valid, mm_per_unit_q16, input ready);
    modport sink (input valid, mm_per_unit_q16, output ready);
endinterface

`default_nettype wire

@@ sv/ds_twr_front.sv @@
// Interval differences, split products and the signed numerator of the ranging formula.
`default_nettype none

module ds_twr_front #(
    parameter int STAMP_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [ds_twr_pkg::ANCHOR_W-1:0]      anchor,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    poll_sent_time,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    reply_received_time,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    final_sent_time,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    poll_received_time,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    reply_sent_time,
    input  wire logic [ds_twr_pkg::STAMP_IN_W-1:0]    final_received_time,
    output logic [2*STAMP_BITS-1:0]                   num,
    output logic [STAMP_BITS+1:0]                     den,
    output ds_twr_pkg::ctrl_t                         ctrl_out
);
    import ds_twr_pkg::*;

    localparam int H  = (STAMP_BITS + 1) / 2;
    localparam int L  = STAMP_BITS - H;
    localparam int NW = 2 * STAMP_BITS;
    localparam int DW = STAMP_BITS + 2;

    logic [STAMP_BITS-1:0] poll_tx, resp_rx, final_tx, poll_rx, resp_tx, final_rx;

    logic [STAMP_BITS-1:0] ra_reg, rb_reg, da_reg, db_reg;
    ctrl_t                 ctrl_a_reg, ctrl_a_next;

    logic [2*H-1:0]        ab_ll_reg, cd_ll_reg;
    logic [STAMP_BITS-1:0] ab_lh_reg, ab_hl_reg, cd_lh_reg, cd_hl_reg;
    logic [2*L-1:0]        ab_hh_reg, cd_hh_reg;
    logic [DW-1:0]         den_b_reg, den_b_next;
    ctrl_t                 ctrl_b_reg, ctrl_b_next;

    logic [STAMP_BITS:0]   ab_mid, cd_mid;
    logic [NW-1:0]         left_c_reg, right_c_reg, left_c_next, right_c_next;
    logic [DW-1:0]         den_c_reg;
    ctrl_t                 ctrl_c_reg;

    logic [NW:0]           sub_wide;
    logic [NW-1:0]         num_reg;
    logic [DW-1:0]         den_d_reg;
    ctrl_t                 ctrl_d_reg, ctrl_d_next;

    assign poll_tx  = STAMP_BITS'(poll_sent_time);
    assign resp_rx  = STAMP_BITS'(reply_received_time);
    assign final_tx = STAMP_BITS'(final_sent_time);
    assign poll_rx  = STAMP_BITS'(poll_received_time);
    assign resp_tx  = STAMP_BITS'(reply_sent_time);
    assign final_rx = STAMP_BITS'(final_received_time);

    always_comb
    begin
        ctrl_a_next        = '0;
        ctrl_a_next.valid  = in_valid;
        ctrl_a_next.anchor = anchor;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg <= resp_rx - poll_tx;
            rb_reg <= final_rx - resp_tx;
            da_reg <= final_tx - resp_rx;
            db_reg <= resp_tx - poll_rx;
        end
    end

    assign den_b_next = DW'(ra_reg) + DW'(rb_reg) + DW'(da_reg) + DW'(db_reg);

    always_comb
    begin
        ctrl_b_next      = ctrl_a_reg;
        ctrl_b_next.zero = (den_b_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_ll_reg <= ra_reg[H-1:0] * rb_reg[H-1:0];
            ab_lh_reg <= ra_reg[H-1:0] * rb_reg[STAMP_BITS-1:H];
            ab_hl_reg <= ra_reg[STAMP_BITS-1:H] * rb_reg[H-1:0];
            ab_hh_reg <= ra_reg[STAMP_BITS-1:H] * rb_reg[STAMP_BITS-1:H];
            cd_ll_reg <= da_reg[H-1:0] * db_reg[H-1:0];
            cd_lh_reg <= da_reg[H-1:0] * db_reg[STAMP_BITS-1:H];
            cd_hl_reg <= da_reg[STAMP_BITS-1:H] * db_reg[H-1:0];
            cd_hh_reg <= da_reg[STAMP_BITS-1:H] * db_reg[STAMP_BITS-1:H];
            den_b_reg <= den_b_next;
        end
    end

    assign ab_mid       = {1'b0, ab_lh_reg} + {1'b0, ab_hl_reg};
    assign cd_mid       = {1'b0, cd_lh_reg} + {1'b0, cd_hl_reg};
    assign left_c_next  = {ab_hh_reg, ab_ll_reg} + (NW'(ab_mid) << H);
    assign right_c_next = {cd_hh_reg, cd_ll_reg} + (NW'(cd_mid) << H);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_c_reg  <= left_c_next;
            right_c_reg <= right_c_next;
            den_c_reg   <= den_b_reg;
        end
    end

    assign sub_wide = {1'b0, left_c_reg} - {1'b0, right_c_reg};

    always_comb
    begin
        ctrl_d_next     = ctrl_c_reg;
        ctrl_d_next.pos = !sub_wide[NW] && (sub_wide[NW-1:0] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= sub_wide[NW-1:0];
            den_d_reg <= den_c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
            ctrl_d_reg <= '0;
        end
        else if (en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
            ctrl_c_reg <= ctrl_b_reg;
            ctrl_d_reg <= ctrl_d_next;
        end
    end

    assign num      = num_reg;
    assign den      = den_d_reg;
    assign ctrl_out = ctrl_d_reg;

endmodule

`default_nettype wire

@@ sv/ds_twr_div.sv @@
// Pipelined restoring divider that retires one quotient bit per stage.
`default_nettype none

module ds_twr_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 34
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    input  wire ds_twr_pkg::ctrl_t  ctrl_in,
    output logic [NUM_W-1:0]        quot,
    output ds_twr_pkg::ctrl_t       ctrl_out
);
    import ds_twr_pkg::*;

    logic [DEN_W-1:0] rem_reg  [NUM_W];
    logic [NUM_W-1:0] nq_reg   [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];
    ctrl_t            ctrl_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] nq_in;
        ctrl_t            ctrl_k;
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign den_in = den;
            assign nq_in  = num;
            assign ctrl_k = ctrl_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign ctrl_k = ctrl_reg[k-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_in};

        always_comb
        begin
            if (!diff[DEN_W+1])
            begin
                rem_next = diff[DEN_W-1:0];
                nq_next  = {nq_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                nq_next  = {nq_in[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                den_reg[k] <= den_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[k] <= ctrl_k;
            end
        end
    end

    assign quot     = nq_reg[NUM_W-1];
    assign ctrl_out = ctrl_reg[NUM_W-1];

endmodule

`default_nettype wire

@@ sv/ds_twr_scale.sv @@
// Conversion of the time of flight to millimeters with clamping and saturation.
`default_nettype none

module ds_twr_scale #(
    parameter int QUOT_W    = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic [QUOT_W-1:0]                  quot,
    input  wire ds_twr_pkg::ctrl_t                  ctrl_in,
    input  wire logic [ds_twr_pkg::SCALE_W-1:0]     scale,
    output logic                                    res_valid,
    output ds_twr_pkg::res_t                        res
);
    import ds_twr_pkg::*;

    localparam int TQ = DIST_W + FRAC_BITS;
    localparam int HW = TQ - MUL_SPLIT;
    localparam int PW = TQ + SCALE_W;
    localparam int SW = PW - FRAC_BITS;

    logic                      big;
    logic [TQ-1:0]             tof;

    logic [MUL_SPLIT+SCALE_W-1:0] p_lo_reg;
    logic [HW+SCALE_W-1:0]        p_hi_reg;
    logic                         sat_a_reg;
    ctrl_t                        ctrl_a_reg;

    logic [PW-1:0]                prod_reg, prod_next;
    logic                         sat_b_reg;
    ctrl_t                        ctrl_b_reg;

    logic [SW-1:0]                shifted;
    logic [DIST_W-1:0]            dist_next;
    res_t                         res_reg;
    logic                         res_valid_reg;

    if (QUOT_W > TQ)
    begin : g_wide
        assign big = |quot[QUOT_W-1:TQ];
        assign tof = quot[TQ-1:0];
    end
    else
    begin : g_narrow
        assign big = 1'b0;
        assign tof = TQ'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg  <= tof[MUL_SPLIT-1:0] * scale;
            p_hi_reg  <= tof[TQ-1:MUL_SPLIT] * scale;
            sat_a_reg <= big && (scale != '0);
        end
    end

    assign prod_next = PW'(p_lo_reg) + (PW'(p_hi_reg) << MUL_SPLIT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            sat_b_reg <= sat_a_reg;
        end
    end

    assign shifted = prod_reg[PW-1:FRAC_BITS];

    always_comb
    begin
        if (ctrl_b_reg.zero || !ctrl_b_reg.pos)
        begin
            dist_next = '0;
        end
        else if (sat_b_reg || (shifted >= SW'(DIST_MAX)))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = shifted[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.anchor_out   <= ctrl_b_reg.anchor;
            res_reg.distance_mm  <= dist_next;
            res_reg.zero_divisor <= ctrl_b_reg.zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg    <= '0;
            ctrl_b_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctrl_a_reg    <= ctrl_in;
            ctrl_b_reg    <= ctrl_a_reg;
            res_valid_reg <= ctrl_b_reg.valid;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ sv/ds_twr_obuf.sv @@
// Output register with a skid entry that decouples the pipeline from the result channel.
`default_nettype none

module ds_twr_obuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ds_twr_pkg::res_t push_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ds_twr_pkg::res_t      out_data,
    output logic                  full
);
    import ds_twr_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_ready && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (push && (!out_valid_reg || out_ready))
        begin
            out_reg <= push_data;
        end

        if (push && out_valid_reg && !out_ready)
        begin
            skid_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign full      = skid_valid_reg;

endmodule

`default_nettype wire

@@ sv/ds_twr_distance_unit.sv @@
// Top level of the double-sided two-way ranging distance unit.
//
// The unit accepts one timestamp set per clock cycle while its skid entry
// is empty. The front end registers intervals, split products, full products
// and the numerator; the restoring divider retires one quotient bit per
// stage over 2*STAMP_BITS stages; the scaler registers split products, their
// sum and the saturated distance; and the output register holds the result.
// A set whose set_valid is low is accepted and produces no result. While the
// result channel stalls, the output register and a skid entry absorb the
// pipeline's output, and the input stops accepting only once both are full.
// The user must write the scale register only when no transaction is in
// flight, which the unit does not enforce; it takes effect for the next set.
`default_nettype none

module ds_twr_distance_unit #(
    parameter int STAMP_BITS      = 32,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ds_twr_set_if.sink       set_in,
    ds_twr_result_if.source  result_out,
    ds_twr_cfg_if.sink       cfg
);
    import ds_twr_pkg::*;

    localparam int NW = 2 * STAMP_BITS;
    localparam int DW = STAMP_BITS + 2;

    logic               en;
    logic               buf_full;
    logic [SCALE_W-1:0] scale_reg;

    logic [NW-1:0]      num;
    logic [DW-1:0]      den;
    ctrl_t              front_ctrl;
    logic [NW-1:0]      quot;
    ctrl_t              div_ctrl;
    logic               res_valid;
    res_t               res;
    res_t               out_data;

    assign en           = !buf_full;
    assign set_in.ready = en;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            scale_reg <= cfg.mm_per_unit_q16;
        end
    end

    ds_twr_front #(
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .in_valid            (set_in.valid && set_in.set_valid),
        .anchor              (set_in.anchor_number),
        .poll_sent_time      (set_in.poll_sent_time),
        .reply_received_time (set_in.reply_received_time),
        .final_sent_time     (set_in.final_sent_time),
        .poll_received_time  (set_in.poll_received_time),
        .reply_sent_time     (set_in.reply_sent_time),
        .final_received_time (set_in.final_received_time),
        .num                 (num),
        .den                 (den),
        .ctrl_out            (front_ctrl)
    );

    ds_twr_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (num),
        .den      (den),
        .ctrl_in  (front_ctrl),
        .quot     (quot),
        .ctrl_out (div_ctrl)
    );

    ds_twr_scale #(
        .QUOT_W    (NW),
        .FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .quot      (quot),
        .ctrl_in   (div_ctrl),
        .scale     (scale_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ds_twr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && res_valid),
        .push_data (res),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign result_out.anchor_out   = out_data.anchor_out;
    assign result_out.distance_mm  = out_data.distance_mm;
    assign result_out.zero_divisor = out_data.zero_divisor;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the double-sided two-way ranging distance unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ds_twr_pkg::*;

    localparam int STAMP_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DRAIN_CYCLES = 2 * STAMP_BITS + 40;
    localparam int SETS_PER_PHASE = 134;
    localparam int PHASES       = 6;

    typedef struct {
        logic                  set_valid;
        logic [ANCHOR_W-1:0]   anchor_number;
        logic [STAMP_IN_W-1:0] poll_sent_time;
        logic [STAMP_IN_W-1:0] reply_received_time;
        logic [STAMP_IN_W-1:0] final_sent_time;
        logic [STAMP_IN_W-1:0] poll_received_time;
        logic [STAMP_IN_W-1:0] reply_sent_time;
        logic [STAMP_IN_W-1:0] final_received_time;
    } ranging_set_t;

    class distance_scoreboard;
        logic [SCALE_W-1:0] scale;
        res_t               expected_q[$];
        int                 errors;
        int                 checked;
        int                 sets_noted;

        function new();
            scale      = SCALE_RESET;
            errors     = 0;
            checked    = 0;
            sets_noted = 0;
        endfunction

        function res_t predict_distance(ranging_set_t s);
            logic [31:0]  ra;
            logic [31:0]  rb;
            logic [31:0]  da;
            logic [31:0]  db;
            logic [63:0]  left;
            logic [63:0]  right;
            logic [33:0]  denom;
            logic [63:0]  tof;
            logic [127:0] scaled;
            res_t         r;
            ra = s.reply_received_time - s.poll_sent_time;
            rb = s.final_received_time - s.reply_sent_time;
            da = s.final_sent_time - s.reply_received_time;
            db = s.reply_sent_time - s.poll_received_time;
            denom = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
            left  = 64'(ra) * 64'(rb);
            right = 64'(da) * 64'(db);
            r.anchor_out   = s.anchor_number;
            r.distance_mm  = '0;
            r.zero_divisor = (denom == '0);
            if (denom != '0 && left > right && scale != '0)
            begin
                tof    = (left - right) / 64'(denom);
                scaled = (128'(tof) * 128'(scale)) >> FRAC_BITS;
                if (scaled >= 128'(DIST_MAX))
                    r.distance_mm = DIST_MAX;
                else
                    r.distance_mm = scaled[DIST_W-1:0];
            end
            return r;
        endfunction

        function void note_set(ranging_set_t s);
            sets_noted++;
            if (s.set_valid)
                expected_q.push_back(predict_distance(s));
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual anchor %0d distance %0d",
                         $time, got.anchor_out, got.distance_mm);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.anchor_out !== want.anchor_out)
            begin
                $display("%0t: anchor_out mismatch, expected %0d actual %0d",
                         $time, want.anchor_out, got.anchor_out);
                errors++;
            end
            if (got.distance_mm !== want.distance_mm)
            begin
                $display("%0t: distance_mm mismatch, expected %0d actual %0d",
                         $time, want.distance_mm, got.distance_mm);
                errors++;
            end
            if (got.zero_divisor !== want.zero_divisor)
            begin
                $display("%0t: zero_divisor mismatch, expected %0d actual %0d",
                         $time, want.zero_divisor, got.zero_divisor);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    distance_scoreboard sb = new();

    ds_twr_set_if    set_if();
    ds_twr_result_if res_if();
    ds_twr_cfg_if    cfg_if();

    ds_twr_distance_unit #(
        .STAMP_BITS      (STAMP_BITS),
        .SCALE_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_in     (set_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_result('{anchor_out:   res_if.anchor_out,
                                  distance_mm:  res_if.distance_mm,
                                  zero_divisor: res_if.zero_divisor});
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic ranging_set_t make_set(logic sv, logic [7:0] anchor,
                                              logic [31:0] poll_tx, logic [31:0] ra,
                                              logic [31:0] da, logic [31:0] poll_rx,
                                              logic [31:0] db, logic [31:0] rb);
        ranging_set_t s;
        s.set_valid           = sv;
        s.anchor_number       = anchor;
        s.poll_sent_time      = poll_tx;
        s.reply_received_time = poll_tx + ra;
        s.final_sent_time     = poll_tx + ra + da;
        s.poll_received_time  = poll_rx;
        s.reply_sent_time     = poll_rx + db;
        s.final_received_time = poll_rx + db + rb;
        return s;
    endfunction

    task automatic send_set(input ranging_set_t s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            set_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        set_if.valid               <= 1'b1;
        set_if.set_valid           <= s.set_valid;
        set_if.anchor_number       <= s.anchor_number;
        set_if.poll_sent_time      <= s.poll_sent_time;
        set_if.reply_received_time <= s.reply_received_time;
        set_if.final_sent_time     <= s.final_sent_time;
        set_if.poll_received_time  <= s.poll_received_time;
        set_if.reply_sent_time     <= s.reply_sent_time;
        set_if.final_received_time <= s.final_received_time;
        do @(posedge clk); while (!set_if.ready);
        sb.note_set(s);
    endtask

    task automatic drain_results();
        set_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        cfg_if.valid           <= 1'b1;
        cfg_if.mm_per_unit_q16 <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.scale = value;
    endtask

    initial
    begin
        logic [SCALE_W-1:0] phase_scale[PHASES];
        ranging_set_t       s;
        int                 random_sets;
        int                 pick;
        int unsigned        tof;
        logic [31:0]        da;
        logic [31:0]        db;
        logic [31:0]        drift_a;
        logic [31:0]        drift_b;

        phase_scale[0] = SCALE_RESET;
        phase_scale[1] = '0;
        phase_scale[2] = 24'hFF_FFFF;
        phase_scale[3] = 24'h01_0000;
        phase_scale[4] = 24'($urandom_range(1, 24'hFF_FFFE));
        phase_scale[5] = SCALE_RESET;

        rst_n                      = 1'b0;
        send_idle_pct              = 14;
        recv_idle_pct              = 79;
        set_if.valid               = 1'b0;
        set_if.set_valid           = 1'b0;
        set_if.anchor_number       = '0;
        set_if.poll_sent_time      = '0;
        set_if.reply_received_time = '0;
        set_if.final_sent_time     = '0;
        set_if.poll_received_time  = '0;
        set_if.reply_sent_time     = '0;
        set_if.final_received_time = '0;
        cfg_if.valid               = 1'b0;
        cfg_if.mm_per_unit_q16     = '0;
        random_sets                = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets at the reset scale.
        send_set(make_set(1'b0, 8'd7, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
        send_set(make_set(1'b0, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                          32'h0));
        send_set(make_set(1'b1, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_set(make_set(1'b1, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                          32'h0));
        send_set(make_set(1'b1, 8'd1, 32'h1000, 32'd602000, 32'd400000, 32'h5000,
                          32'd600000, 32'd402000));
        send_set(make_set(1'b1, 8'd2, 32'hFFFF_FFF0, 32'd2100, 32'd3000, 32'hFFFF_FF00,
                          32'd2000, 32'd3100));
        send_set(make_set(1'b1, 8'd3, 32'h10, 32'd100, 32'd5000, 32'h20, 32'd5000,
                          32'd100));
        send_set(make_set(1'b1, 8'd4, 32'h0, 32'd100, 32'd100, 32'h0, 32'd100, 32'd100));
        send_set(make_set(1'b1, 8'd5, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                          32'hFFFF_FFFF));
        send_set(make_set(1'b1, 8'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_set(make_set(1'b1, 8'd8, 32'h0, 32'd1002, 32'd1000, 32'h0, 32'd1000,
                          32'd1002));
        send_set(make_set(1'b1, 8'd9, 32'h0, 32'd2, 32'd1, 32'h0, 32'd1, 32'd1));
        send_set(make_set(1'b1, 8'd10, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'd1));
        send_set(make_set(1'b1, 8'd11, 32'hAAAA_AAAA, 32'h8000_0000, 32'h1,
                          32'h5555_5555, 32'h1, 32'h8000_0000));
        send_set(make_set(1'b1, 8'hA5, 32'h1234_5678, 32'd1, 32'h0, 32'h8765_4321,
                          32'h0, 32'd1));
        send_set(make_set(1'b1, 8'h5A, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                          32'h7FFF_FFFF, 32'h8000_0000));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase > 0)
            begin
                drain_results();
                write_scale(phase_scale[phase]);
            end
            while (random_sets < SETS_PER_PHASE * (phase + 1))
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    s = make_set(1'b0, 8'($urandom), $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                else if (pick < 60)
                begin
                    tof     = ($urandom_range(9) == 0) ? $urandom_range(3)
                                                       : $urandom_range(30000);
                    da      = $urandom >> $urandom_range(2, 31);
                    db      = $urandom >> $urandom_range(2, 31);
                    drift_a = 32'($urandom_range(64)) - 32'd32;
                    drift_b = 32'($urandom_range(64)) - 32'd32;
                    s = make_set(1'b1, 8'($urandom), $urandom, db + 2 * tof + drift_a, da,
                                 $urandom, db, da + 2 * tof + drift_b);
                end
                else if (pick < 75)
                    s = make_set(1'b1, 8'($urandom), $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                else if (pick < 80)
                    s = make_set(1'b1, 8'($urandom), $urandom, 32'h0, 32'h0, $urandom,
                                 32'h0, 32'h0);
                else if (pick < 90)
                    s = make_set(1'b1, 8'($urandom), $urandom, $urandom | 32'hC000_0000,
                                 $urandom_range(1000), $urandom, $urandom_range(1000),
                                 $urandom | 32'hC000_0000);
                else
                    s = make_set(1'b1, 8'($urandom), $urandom, $urandom_range(5000),
                                 $urandom | 32'h0010_0000, $urandom,
                                 $urandom | 32'h0010_0000, $urandom_range(5000));
                send_set(s);
                random_sets++;
            end
        end
        drain_results();

        $display("Sent %0d timestamp sets and checked %0d distance results over %0d scales,",
                 sb.sets_noted, sb.checked, PHASES);
        $display("including zero and full-scale settings and three back-pressure mixes.");
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
